// File: hdl/tpid_pkg.sv
// Shared types, constants and colour expansion for the tiled palette icon decoder.
`timescale 1ns / 1ps
`default_nettype none

package tpid_pkg;

   localparam int PAL_DEPTH     = 16;
   localparam int PAL_IDX_W     = 4;
   localparam int COLOR_W       = 15;
   localparam int PAL_COLOR_W   = 16;
   localparam int BYTE_IDX_W    = 9;
   localparam int ICON_BYTE_W   = 8;
   localparam int COORD_W       = 5;
   localparam int RGBA_W        = 32;

   // request tdata packing, lowest bit first
   localparam int REQ_PAL_IDX_LSB   = 0;
   localparam int REQ_PAL_COLOR_LSB = REQ_PAL_IDX_LSB + PAL_IDX_W;
   localparam int REQ_BYTE_IDX_LSB  = REQ_PAL_COLOR_LSB + PAL_COLOR_W;
   localparam int REQ_ICON_LSB      = REQ_BYTE_IDX_LSB + BYTE_IDX_W;
   localparam int REQ_USED_W        = REQ_ICON_LSB + ICON_BYTE_W;
   localparam int REQ_DATA_W        = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata packing, lowest bit first
   localparam int RSP_X_LSB     = 0;
   localparam int RSP_Y_LSB     = RSP_X_LSB + COORD_W;
   localparam int RSP_LEFT_LSB  = RSP_Y_LSB + COORD_W;
   localparam int RSP_RIGHT_LSB = RSP_LEFT_LSB + RGBA_W;
   localparam int RSP_USED_W    = RSP_RIGHT_LSB + RGBA_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = '1;
   localparam logic [7:0]            ALPHA_OPAQUE  = 8'hFF;
   localparam logic [7:0]            ALPHA_CLEAR   = 8'h00;

   typedef enum logic {
      FUNC_PAL_WRITE = 1'b0,
      FUNC_DECODE    = 1'b1
   } func_type;

   typedef logic [COLOR_W-1:0] color_type;

   // BGR555 to RGBA8888; palette index 0 is transparent but keeps its RGB
   function automatic logic [RGBA_W-1:0] expand_color(input color_type c,
                                                       input logic [PAL_IDX_W-1:0] nib);
      logic [7:0] alpha;
      alpha = (nib == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      return {c[4:0], 3'b000, c[9:5], 3'b000, c[14:10], 3'b000, alpha};
   endfunction

endpackage

`default_nettype wire

// File: hdl/tiled_palette_icon_decoder.sv
// Top level: 4bpp tiled icon decoder with a 16-entry BGR555 palette.
// A decode goes through the input register and then the result register before it reaches rsp.
// Throughput: one transfer per cycle unless rsp stalls; set by the input and result registers.
// A palette write takes effect as it leaves the input register and yields no result.
// Synchronous reset clears the valid flags only; palette contents are undefined until written.
// The response register lets the next request be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module tiled_palette_icon_decoder
   import tpid_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // pal_index[3:0], pal_color[19:4], byte_index[28:20], icon_byte[36:29], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func[0]
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // pix_x[4:0], pix_y[9:5], left_rgba[41:10], right_rgba[73:42], zero pad
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // last_pair
   output      logic                  rsp_tlast
);

   // input register
   logic                      s1_valid_ff, s1_valid_in;
   func_type                  s1_func_ff;
   logic [PAL_IDX_W-1:0]      s1_pal_idx_ff;
   color_type                 s1_color_ff;
   logic [BYTE_IDX_W-1:0]     s1_byte_idx_ff;
   logic [ICON_BYTE_W-1:0]    s1_icon_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        rsp_x_ff, rsp_y_ff;
   logic [RGBA_W-1:0]         rsp_left_ff, rsp_right_ff;
   logic                      rsp_last_ff;

   color_type                 palette [PAL_DEPTH];

   logic                      out_free;
   logic                      s1_go;
   logic                      req_take;
   logic                      s1_decode_go;
   logic                      s1_write_go;
   logic [PAL_IDX_W-1:0]      left_nib, right_nib;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign s1_go        = s1_valid_ff && ((s1_func_ff == FUNC_PAL_WRITE) || out_free);
   assign s1_decode_go = s1_go && (s1_func_ff == FUNC_DECODE);
   assign s1_write_go  = s1_go && (s1_func_ff == FUNC_PAL_WRITE);
   assign req_tready   = !s1_valid_ff || s1_go;
   assign req_take     = req_tvalid && req_tready;

   assign left_nib  = s1_icon_ff[PAL_IDX_W-1:0];
   assign right_nib = s1_icon_ff[ICON_BYTE_W-1:PAL_IDX_W];

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_go);
      if (s1_decode_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff     <= func_type'(req_tuser);
         s1_pal_idx_ff  <= req_tdata[REQ_PAL_IDX_LSB +: PAL_IDX_W];
         s1_color_ff    <= req_tdata[REQ_PAL_COLOR_LSB +: COLOR_W];
         s1_byte_idx_ff <= req_tdata[REQ_BYTE_IDX_LSB +: BYTE_IDX_W];
         s1_icon_ff     <= req_tdata[REQ_ICON_LSB +: ICON_BYTE_W];
      end
   end

   // palette: one write port, two combinational read ports
   always_ff @(posedge clock) begin
      if (s1_write_go) begin
         palette[s1_pal_idx_ff] <= s1_color_ff;
      end
   end

   // tile = byte_index[8:5], byte within tile = byte_index[4:0]; four bytes per row
   always_ff @(posedge clock) begin
      if (s1_decode_go) begin
         rsp_x_ff     <= {s1_byte_idx_ff[6:5], s1_byte_idx_ff[1:0], 1'b0};
         rsp_y_ff     <= {s1_byte_idx_ff[8:7], s1_byte_idx_ff[4:2]};
         rsp_left_ff  <= expand_color(palette[left_nib], left_nib);
         rsp_right_ff <= expand_color(palette[right_nib], right_nib);
         rsp_last_ff  <= (s1_byte_idx_ff == LAST_BYTE_IDX);
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_X_LSB +: COORD_W]    = rsp_x_ff;
      rsp_tdata[RSP_Y_LSB +: COORD_W]    = rsp_y_ff;
      rsp_tdata[RSP_LEFT_LSB +: RGBA_W]  = rsp_left_ff;
      rsp_tdata[RSP_RIGHT_LSB +: RGBA_W] = rsp_right_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_x_ff == 5'd30 && rsp_y_ff == 5'd31)
      else $error("last pair not at bottom right corner");

   a_x_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_x_ff[0])
      else $error("pixel pair column is odd");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_left_ff[7:0] == ALPHA_CLEAR || rsp_left_ff[7:0] == ALPHA_OPAQUE)
                    && (rsp_right_ff[7:0] == ALPHA_CLEAR || rsp_right_ff[7:0] == ALPHA_OPAQUE))
      else $error("alpha is neither clear nor opaque");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      s1_write_go && out_free |=> !rsp_valid_ff)
      else $error("palette write produced a result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("valid flags set after reset");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the tiled palette icon decoder.
`timescale 1ns / 1ps

module testbench
   import tpid_pkg::*;
();

   localparam int TAIL_ITEMS    = 250;   // no idling once this few items are left
   localparam int DRAIN_AT      = 700;   // sender waits for all results after this item
   localparam int LONG_HOLD_AT  = 300;   // receiver holds off after this many results
   localparam int LONG_HOLD_LEN = 60;
   localparam int WATCHDOG_MAX  = 1000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      func_type                func;
      logic [PAL_IDX_W-1:0]    pal_index;
      logic [PAL_COLOR_W-1:0]  pal_color;
      logic [BYTE_IDX_W-1:0]   byte_index;
      logic [ICON_BYTE_W-1:0]  icon_byte;
   } icon_req_type;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [RGBA_W-1:0]  left;
      logic [RGBA_W-1:0]  right;
      logic               last;
   } pixel_pair_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   icon_req_type   pending_reqs[$];
   pixel_pair_type expected_pixels[$];
   logic [COLOR_W-1:0] pal_shadow[PAL_DEPTH];

   logic req_fire       = 1'b0;
   int   send_gap       = 0;
   int   sent_count     = 0;
   logic drain_hold     = 1'b0;
   int   recv_hold      = 0;
   logic long_hold_done = 1'b0;
   int   pixel_count    = 0;
   int   error_count    = 0;
   int   idle_cycles    = 0;

   tiled_palette_icon_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [RGBA_W-1:0] bgr_to_rgba(logic [COLOR_W-1:0] bgr,
                                                     logic [PAL_IDX_W-1:0] nib);
      logic [7:0] alpha;
      alpha = (nib == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      return {bgr[4:0], 3'b000, bgr[9:5], 3'b000, bgr[14:10], 3'b000, alpha};
   endfunction

   // raster position: tiles are 4 across, each tile row holds 4 bytes
   function automatic pixel_pair_type decode_pair(logic [BYTE_IDX_W-1:0] bidx,
                                                  logic [ICON_BYTE_W-1:0] ib);
      pixel_pair_type p;
      p.x     = {bidx[6:5], bidx[1:0], 1'b0};
      p.y     = {bidx[8:7], bidx[4:2]};
      p.left  = bgr_to_rgba(pal_shadow[ib[3:0]], ib[3:0]);
      p.right = bgr_to_rgba(pal_shadow[ib[7:4]], ib[7:4]);
      p.last  = (bidx == LAST_BYTE_IDX);
      return p;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(icon_req_type r);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_PAL_IDX_LSB   +: PAL_IDX_W]   = r.pal_index;
      d[REQ_PAL_COLOR_LSB +: PAL_COLOR_W] = r.pal_color;
      d[REQ_BYTE_IDX_LSB  +: BYTE_IDX_W]  = r.byte_index;
      d[REQ_ICON_LSB      +: ICON_BYTE_W] = r.icon_byte;
      return d;
   endfunction

   task automatic push_req(func_type f, int unsigned pidx, int unsigned pcol,
                           int unsigned bidx, int unsigned ib);
      icon_req_type r;
      r.func       = f;
      r.pal_index  = pidx[PAL_IDX_W-1:0];
      r.pal_color  = pcol[PAL_COLOR_W-1:0];
      r.byte_index = bidx[BYTE_IDX_W-1:0];
      r.icon_byte  = ib[ICON_BYTE_W-1:0];
      pending_reqs.push_back(r);
   endtask

   task automatic push_rand_write();
      push_req(FUNC_PAL_WRITE, $urandom_range(0, 15), $urandom_range(0, 65535),
               $urandom_range(0, 511), $urandom_range(0, 255));
   endtask

   task automatic push_rand_decode(int unsigned bidx);
      push_req(FUNC_DECODE, $urandom_range(0, 15), $urandom_range(0, 65535),
               bidx, $urandom_range(0, 255));
   endtask

   // driver: launches the next item once the previous transfer has gone
   always @(negedge clock) begin
      icon_req_type nxt;
      logic         next_valid;
      next_valid = req_tvalid;
      if (req_fire)
         next_valid = 1'b0;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!next_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (!(drain_hold && expected_pixels.size() != 0) &&
                      pending_reqs.size() != 0) begin
            drain_hold = 1'b0;
            nxt = pending_reqs.pop_front();
            req_tdata  <= pack_req(nxt);
            req_tuser  <= nxt.func;
            next_valid = 1'b1;
            sent_count++;
            if (sent_count == DRAIN_AT)
               drain_hold = 1'b1;
            if (pending_reqs.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 9);
         end
      end
      req_tvalid <= next_valid;
   end

   // receiver: random stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      logic next_ready;
      if (!long_hold_done && pixel_count >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         recv_hold      = LONG_HOLD_LEN;
      end
      if (recv_hold > 0) begin
         recv_hold--;
         next_ready = 1'b0;
      end else if (pending_reqs.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
         recv_hold  = $urandom_range(0, 8);
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
      end
      rsp_tready <= next_ready;
   end

   // monitor: prediction on each req transfer, check on each rsp transfer
   always @(posedge clock) begin
      pixel_pair_type got;
      pixel_pair_type want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x     = rsp_tdata[RSP_X_LSB     +: COORD_W];
         got.y     = rsp_tdata[RSP_Y_LSB     +: COORD_W];
         got.left  = rsp_tdata[RSP_LEFT_LSB  +: RGBA_W];
         got.right = rsp_tdata[RSP_RIGHT_LSB +: RGBA_W];
         got.last  = rsp_tlast;
         pixel_count++;
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected pixel pair x=%0d y=%0d l=%h r=%h last=%b",
                        $realtime, got.x, got.y, got.left, got.right, got.last);
         end else begin
            want = expected_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.left !== want.left ||
                got.right !== want.right || got.last !== want.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: pixel pair mismatch: want x=%0d y=%0d l=%h r=%h last=%b,",
                            " got x=%0d y=%0d l=%h r=%h last=%b"}, $realtime,
                           want.x, want.y, want.left, want.right, want.last,
                           got.x, got.y, got.left, got.right, got.last);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser == FUNC_PAL_WRITE)
            pal_shadow[req_tdata[REQ_PAL_IDX_LSB +: PAL_IDX_W]] =
               req_tdata[REQ_PAL_COLOR_LSB +: COLOR_W];
         else
            expected_pixels.push_back(decode_pair(req_tdata[REQ_BYTE_IDX_LSB +: BYTE_IDX_W],
                                                  req_tdata[REQ_ICON_LSB +: ICON_BYTE_W]));
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      // directed: every palette entry written first, so no decode hits an empty one
      push_req(FUNC_PAL_WRITE, 0, 16'h7FFF, 0, 0);
      push_req(FUNC_PAL_WRITE, 1, 16'h8000, 0, 0);     // only the ignored top bit
      push_req(FUNC_PAL_WRITE, 2, 16'hFFFF, 0, 0);
      push_req(FUNC_PAL_WRITE, 3, 16'h001F, 0, 0);
      push_req(FUNC_PAL_WRITE, 4, 16'h03E0, 0, 0);
      push_req(FUNC_PAL_WRITE, 5, 16'h7C00, 0, 0);
      for (int i = 6; i < 15; i++)
         push_req(FUNC_PAL_WRITE, i, $urandom_range(0, 65535), 0, 0);
      push_req(FUNC_PAL_WRITE, 15, $urandom_range(0, 65535), 511, 255);
      push_req(FUNC_DECODE, 0, 0, 0, 8'h00);           // transparent, RGB kept
      push_req(FUNC_DECODE, 0, 0, 511, 8'hFF);         // last byte of the icon
      push_req(FUNC_DECODE, 0, 0, 31, 8'h10);
      push_req(FUNC_DECODE, 0, 0, 32, 8'h01);
      push_req(FUNC_DECODE, 0, 0, 480, 8'h32);
      push_req(FUNC_DECODE, 0, 0, 3, 8'h54);
      push_req(FUNC_DECODE, 15, 16'hFFFF, 28, 8'hF0);  // palette fields ignored
      push_req(FUNC_PAL_WRITE, 0, 16'h0000, 0, 0);
      push_req(FUNC_DECODE, 0, 0, 255, 8'h0F);
      // one whole icon in byte-index (tile) order, palette updates mixed in
      for (int i = 0; i < 512; i++) begin
         if ($urandom_range(0, 11) == 0)
            push_rand_write();
         push_rand_decode(i);
      end
      for (int i = 0; i < 1000; i++) begin
         if ($urandom_range(0, 4) == 0)
            push_rand_write();
         else
            push_rand_decode($urandom_range(0, 511));
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
